>>> rtl/lom_pkg.sv
// Package for the latency outlier monitor: field widths, sizes and codes.
// Used by latency_outlier_monitor_top; depends on nothing else.
package lom_pkg;

    // Field and state widths
    localparam int LAT_W      = 40;            // latency, unsigned fixed point, 32 fraction bits, saturated
    localparam int SQ_W       = 2 * LAT_W - 32; // mean of squares
    localparam int SD_W       = LAT_W - 16;    // standard deviation
    localparam int THR_W      = LAT_W + 2;     // trained threshold
    localparam int TOT_W      = 32;            // outlier counter
    localparam int SKIP_W     = 6;
    localparam int ALPHA_W    = 4;
    localparam int CMD_W      = 2;
    localparam int PHASE_W    = 2;
    localparam int EMA_W      = SQ_W + 16;     // EMA working sum

    // Sizes
    localparam int CLASS_COUNT = 3;
    localparam int TRAIN_N     = 500;
    localparam int PCT_IDX     = TRAIN_N * 95 / 100;
    localparam int CNT_W       = $clog2(TRAIN_N + 1);
    localparam int IDX_W       = $clog2(TRAIN_N);
    localparam int MEM_DEPTH   = CLASS_COUNT * TRAIN_N;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int STEP_W      = $clog2(LAT_W);

    // Reset values of the configuration registers
    localparam logic [SKIP_W-1:0]  SKIP_RESET  = SKIP_W'(50);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(14);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = SKIP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b1;

    // Stream widths
    localparam int IN_TDATA_W  = ((LAT_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_BITS    = 2 + TOT_W + LAT_W + SD_W + THR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W = PHASE_W;

    // Result phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_SKIP   = 2'd0,
        PH_TRAIN  = 2'd1,
        PH_TRACK  = 2'd2,
        PH_IGNORE = 2'd3
    } t_phase;

endpackage

>>> rtl/latency_outlier_monitor_top.sv
// Latency outlier monitor: per-class skip, training, percentile threshold
// and EMA / standard deviation tracking. Depends on lom_pkg.
//
// Usage:
//   Slave stream takes one I/O completion per transaction: tdata holds the
//   latency (unsigned fixed point, 32 fraction bits), tuser the command
//   class (read, write, trim, other). Master stream returns one result
//   per input: tuser holds the phase, tdata the flags, outlier total and
//   the class statistics. Configuration (skip_count index 0, alpha_shift
//   index 1) is written through i_cfg_we / i_cfg_index / i_cfg_data; the
//   user must do so only while the block is idle, which it does not enforce.
// Processing:
//   Ignored, skipping and training samples go straight to the output state.
//   Tracking samples run a bit-serial 40x40 multiplier twice (y*y and
//   ema*ema) and a bit-serial square root; one item is processed at a time.
//   The last training sample of a class runs a percentile selection over
//   the training memory (one read port), scanning all samples per candidate.
// Reset and stall:
//   Synchronous reset clears all class statistics and restores the
//   configuration defaults; training memory is not cleared. A new input
//   is taken while a finished result waits in the output register; the
//   next result waits in its last state until the receiver takes it.
module latency_outlier_monitor_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: latency[39:0]
    input  logic [lom_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: command[1:0]
    input  logic [lom_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: over_threshold[0], over_spread[1], outlier_total[33:2],
    //        mean_estimate[73:34], spread_estimate[97:74],
    //        worst_threshold[139:98], zero pad above
    output logic [lom_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: phase[1:0]
    output logic [lom_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [lom_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lom_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lom_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_SEL_RD, ST_SEL_CAND, ST_SEL_SCAN, ST_SEL_DONE,
        ST_CHECK, ST_EMA_A, ST_EMA_B, ST_SQ, ST_EMSS_A, ST_EMSS_B, ST_M2,
        ST_DIFF, ST_SQRT, ST_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [SKIP_W-1:0]  r_skip;
    logic [ALPHA_W-1:0] r_alpha;

    // Current transaction
    logic [CMD_W-1:0]  r_cls;
    logic [LAT_W-1:0]  r_lat;
    t_phase            r_phase;
    logic              r_over_thr;
    logic              r_over_sd;
    logic [MEM_AW-1:0] r_base;

    // Per-class statistics
    logic [SKIP_W-1:0] r_skipped [CLASS_COUNT];
    logic [CNT_W-1:0]  r_trained [CLASS_COUNT];
    logic [THR_W-1:0]  r_thr     [CLASS_COUNT];
    logic [TOT_W-1:0]  r_total   [CLASS_COUNT];
    logic [LAT_W-1:0]  r_mean    [CLASS_COUNT];
    logic [SQ_W-1:0]   r_emss    [CLASS_COUNT];
    logic [SD_W-1:0]   r_sd      [CLASS_COUNT];

    // Percentile selection
    logic [CNT_W-1:0]  r_sel_i;
    logic [CNT_W-1:0]  r_j;
    logic              r_rd_ok;
    logic [LAT_W-1:0]  r_cand;
    logic [CNT_W-1:0]  r_lt;
    logic [CNT_W-1:0]  r_le;

    // Serial multiplier, EMA sum, square root
    logic [LAT_W-1:0]  r_mul_a;
    logic [LAT_W-1:0]  r_acc_hi;
    logic [LAT_W-1:0]  r_acc_lo;
    logic [STEP_W-1:0] r_step;
    logic [EMA_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_rad;
    logic [SD_W+1:0]   r_rem;
    logic [SD_W-1:0]   r_root;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TUSER_W-1:0] r_out_user;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Training memory
    logic [LAT_W-1:0]  r_mem [MEM_DEPTH];
    logic [LAT_W-1:0]  r_rd_data;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [MEM_AW-1:0] mem_raddr;

    // Combinational helpers
    logic [LAT_W:0]    n_mul_sum;
    logic [SQ_W-1:0]   prod_q;
    logic [SD_W+3:0]   n_rem2;
    logic [SD_W+3:0]   n_trial;
    logic              n_root_ge;
    logic [SQ_W-1:0]   ema_old;
    logic [SQ_W-1:0]   ema_new;
    logic [EMA_W-1:0]  n_sum;
    logic [EMA_W-1:0]  sum_shr;
    logic [THR_W-1:0]  spread_lim;
    logic              n_over_thr;
    logic              n_over_sd;
    logic              cls_ignored;
    logic              out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign cls_ignored   = ({1'b0, r_cls} >= (CMD_W + 1)'(CLASS_COUNT));

    // Multiplier step: add multiplicand on low bit, shift right
    assign n_mul_sum = {1'b0, r_acc_hi} + (r_acc_lo[0] ? {1'b0, r_mul_a} : '0);
    // Product shifted right by 32
    assign prod_q    = {r_acc_hi, r_acc_lo[LAT_W-1:32]};

    // Square root step: one result bit per cycle
    assign n_rem2    = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign n_trial   = {2'b00, r_root, 2'b01};
    assign n_root_ge = (n_rem2 >= n_trial);

    // EMA working sum: new + old * 2^a - old
    always_comb begin
        if (r_state == ST_EMSS_A) begin
            ema_old = r_emss[r_cls];
            ema_new = prod_q;
        end else begin
            ema_old = SQ_W'(r_mean[r_cls]);
            ema_new = SQ_W'(r_lat);
        end
    end
    assign n_sum   = EMA_W'(ema_new) + (EMA_W'(ema_old) << r_alpha) - EMA_W'(ema_old);
    assign sum_shr = r_sum >> r_alpha;

    // Outlier checks against threshold and ema + 5*sd
    assign spread_lim = THR_W'(r_mean[r_cls]) + (THR_W'(r_sd[r_cls]) << 2)
                      + THR_W'(r_sd[r_cls]);
    assign n_over_thr = (THR_W'(r_lat) > r_thr[r_cls]);
    assign n_over_sd  = (r_sd[r_cls] != '0) && (THR_W'(r_lat) > spread_lim);

    // Memory address selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_base + MEM_AW'(r_trained[r_cls]);
        mem_raddr = r_base + MEM_AW'(r_j);
        if (r_state == ST_SEL_RD) begin
            mem_raddr = r_base + MEM_AW'(r_sel_i);
        end
        if (r_state == ST_DISPATCH && !cls_ignored
            && !(r_skipped[r_cls] < r_skip)
            && r_trained[r_cls] < CNT_W'(TRAIN_N)) begin
            mem_we = 1'b1;
        end
    end

    // Training memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_lat;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Control, statistics and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_skip      <= SKIP_RESET;
            r_alpha     <= ALPHA_RESET;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_skipped[c] <= '0;
                r_trained[c] <= '0;
                r_thr[c]     <= '0;
                r_total[c]   <= '0;
                r_mean[c]    <= '0;
                r_emss[c]    <= '0;
                r_sd[c]      <= '0;
            end
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SKIP:  r_skip  <= i_cfg_data;
                    CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (r_out_valid && m_axis_tready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cls   <= s_axis_tuser;
                        r_lat   <= s_axis_tdata[LAT_W-1:0];
                        r_base  <= MEM_AW'(s_axis_tuser) * MEM_AW'(TRAIN_N);
                        r_state <= ST_DISPATCH;
                    end
                end

                // Pick the phase of the class
                ST_DISPATCH: begin
                    r_over_thr <= 1'b0;
                    r_over_sd  <= 1'b0;
                    if (cls_ignored) begin
                        r_phase <= PH_IGNORE;
                        r_state <= ST_OUT;
                    end else if (r_skipped[r_cls] < r_skip) begin
                        r_skipped[r_cls] <= r_skipped[r_cls] + 1'b1;
                        r_phase <= PH_SKIP;
                        r_state <= ST_OUT;
                    end else if (r_trained[r_cls] < CNT_W'(TRAIN_N)) begin
                        r_trained[r_cls] <= r_trained[r_cls] + 1'b1;
                        r_phase <= PH_TRAIN;
                        r_sel_i <= '0;
                        if (r_trained[r_cls] == CNT_W'(TRAIN_N - 1)) begin
                            r_state <= ST_SEL_RD;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_phase <= PH_TRACK;
                        r_state <= ST_CHECK;
                    end
                end

                // Percentile: read a candidate, count smaller and not-larger
                ST_SEL_RD: begin
                    r_state <= ST_SEL_CAND;
                end

                ST_SEL_CAND: begin
                    r_cand  <= r_rd_data;
                    r_j     <= '0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_rd_ok <= 1'b0;
                    r_state <= ST_SEL_SCAN;
                end

                ST_SEL_SCAN: begin
                    if (r_rd_ok) begin
                        if (r_rd_data < r_cand) begin
                            r_lt <= r_lt + 1'b1;
                        end
                        if (r_rd_data <= r_cand) begin
                            r_le <= r_le + 1'b1;
                        end
                    end
                    if (r_j != CNT_W'(TRAIN_N)) begin
                        r_j     <= r_j + 1'b1;
                        r_rd_ok <= 1'b1;
                    end else begin
                        r_rd_ok <= 1'b0;
                        if (!r_rd_ok) begin
                            r_state <= ST_SEL_DONE;
                        end
                    end
                end

                ST_SEL_DONE: begin
                    if (r_lt <= CNT_W'(PCT_IDX) && r_le > CNT_W'(PCT_IDX)) begin
                        r_thr[r_cls] <= {r_cand, 2'b00};
                        r_state      <= ST_OUT;
                    end else begin
                        r_sel_i <= r_sel_i + 1'b1;
                        r_state <= ST_SEL_RD;
                    end
                end

                // Tracking: flags and counter
                ST_CHECK: begin
                    r_over_thr     <= n_over_thr;
                    r_over_sd      <= n_over_sd;
                    r_total[r_cls] <= r_total[r_cls] + TOT_W'(n_over_thr)
                                    + TOT_W'(n_over_sd);
                    r_state        <= ST_EMA_A;
                end

                ST_EMA_A: begin
                    r_sum   <= n_sum;
                    r_state <= ST_EMA_B;
                end

                // Store new mean, start y*y
                ST_EMA_B: begin
                    r_mean[r_cls] <= sum_shr[LAT_W-1:0];
                    r_mul_a       <= r_lat;
                    r_acc_lo      <= r_lat;
                    r_acc_hi      <= '0;
                    r_step        <= '0;
                    r_state       <= ST_SQ;
                end

                ST_SQ, ST_M2: begin
                    r_acc_hi <= n_mul_sum[LAT_W:1];
                    r_acc_lo <= {n_mul_sum[0], r_acc_lo[LAT_W-1:1]};
                    r_step   <= r_step + 1'b1;
                    if (r_step == STEP_W'(LAT_W - 1)) begin
                        r_state <= (r_state == ST_SQ) ? ST_EMSS_A : ST_DIFF;
                    end
                end

                ST_EMSS_A: begin
                    r_sum   <= n_sum;
                    r_state <= ST_EMSS_B;
                end

                // Store new mean of squares, start ema*ema
                ST_EMSS_B: begin
                    r_emss[r_cls] <= sum_shr[SQ_W-1:0];
                    r_mul_a       <= r_mean[r_cls];
                    r_acc_lo      <= r_mean[r_cls];
                    r_acc_hi      <= '0;
                    r_step        <= '0;
                    r_state       <= ST_M2;
                end

                ST_DIFF: begin
                    if (r_emss[r_cls] >= prod_q) begin
                        r_rad   <= r_emss[r_cls] - prod_q;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_sd[r_cls] <= '0;
                        r_state     <= ST_OUT;
                    end
                end

                ST_SQRT: begin
                    r_rad <= {r_rad[SQ_W-3:0], 2'b00};
                    if (n_root_ge) begin
                        r_rem  <= (SD_W + 2)'(n_rem2 - n_trial);
                        r_root <= {r_root[SD_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem2[SD_W+1:0];
                        r_root <= {r_root[SD_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SD_W - 1)) begin
                        r_sd[r_cls] <= {r_root[SD_W-2:0], n_root_ge};
                        r_state     <= ST_OUT;
                    end
                end

                // Hold until the output register is free
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_phase;
                        if (r_phase == PH_IGNORE) begin
                            r_out_data <= '0;
                        end else begin
                            r_out_data <= OUT_TDATA_W'({r_thr[r_cls], r_sd[r_cls],
                                r_mean[r_cls], r_total[r_cls], r_over_sd, r_over_thr});
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
